### sv/svac_pkg.sv
`default_nettype none

package svac_pkg;

    // Width of every item and result field on the ports.
    localparam int FIELD_W = 16;

    // Defaults for the top-level parameters.
    localparam int COMP_WIDTH_DEF    = 16;
    localparam int COS_FRAC_BITS_DEF = 14;

    typedef struct packed {
        logic signed [FIELD_W-1:0] a_x;
        logic signed [FIELD_W-1:0] a_y;
        logic signed [FIELD_W-1:0] a_z;
        logic signed [FIELD_W-1:0] b_x;
        logic signed [FIELD_W-1:0] b_y;
        logic signed [FIELD_W-1:0] b_z;
        logic signed [FIELD_W-1:0] c_x;
        logic signed [FIELD_W-1:0] c_y;
        logic signed [FIELD_W-1:0] c_z;
    } svac_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] cos_ra;
        logic signed [FIELD_W-1:0] cos_rb;
        logic signed [FIELD_W-1:0] cos_rc;
    } svac_result_t;

endpackage

`default_nettype wire

### sv/svac_lane.sv
`default_nettype none

module svac_lane #(
    parameter int COMP_WIDTH    = svac_pkg::COMP_WIDTH_DEF,
    parameter int COS_FRAC_BITS = svac_pkg::COS_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  src_valid,
    input  logic [2*(COMP_WIDTH+2)-1:0]           r2,
    input  logic [2*COMP_WIDTH-1:0]               v2,
    input  logic signed [2*COMP_WIDTH+2:0]        dot,
    output logic                                  dst_valid,
    output logic signed [svac_pkg::FIELD_W-1:0]   cos_val
);
    import svac_pkg::*;

    localparam int R2W = 2 * (COMP_WIDTH + 2);
    localparam int V2W = 2 * COMP_WIDTH;
    localparam int DW  = 2 * COMP_WIDTH + 3;
    localparam int RH  = (R2W + 1) / 2;
    localparam int VH  = (V2W + 1) / 2;
    localparam int PW  = R2W + V2W;
    localparam int SW  = (PW + 1) / 2;
    localparam int XW  = 2 * SW;
    localparam int FW  = COS_FRAC_BITS;
    localparam int QW  = FW + 2;
    localparam logic [QW-1:0] ONE = {1'b0, 1'b1, {FW{1'b0}}};

    typedef struct packed {
        logic                 rz;
        logic                 vz;
        logic signed [DW-1:0] dot;
    } side_t;

    typedef struct packed {
        logic rz;
        logic vz;
        logic neg;
        logic sat;
    } dflag_t;

    // Partial products of |R|^2 * |V|^2.
    logic                          pv_reg;
    side_t                         ps_reg;
    logic [RH+VH-1:0]              ll_reg;
    logic [RH+V2W-VH-1:0]          lh_reg;
    logic [R2W-RH+VH-1:0]          hl_reg;
    logic [PW-RH-VH-1:0]           hh_reg;
    logic [RH+VH-1:0]              ll_next;
    logic [RH+V2W-VH-1:0]          lh_next;
    logic [R2W-RH+VH-1:0]          hl_next;
    logic [PW-RH-VH-1:0]           hh_next;
    logic [XW-1:0]                 prod;

    // Square root, one result bit per stage.
    logic                          sv_reg    [0:SW];
    side_t                         ss_reg    [0:SW];
    logic [XW-1:0]                 sx_reg    [0:SW];
    logic [SW:0]                   srem_reg  [0:SW];
    logic [SW-1:0]                 sroot_reg [0:SW];
    logic [XW-1:0]                 sx_next    [1:SW];
    logic [SW:0]                   srem_next  [1:SW];
    logic [SW-1:0]                 sroot_next [1:SW];

    // Restoring division, one quotient bit per stage.
    logic                          dv_reg   [0:FW];
    dflag_t                        df_reg   [0:FW];
    logic [SW-1:0]                 ds_reg   [0:FW];
    logic [SW-1:0]                 drem_reg [0:FW];
    logic [FW-1:0]                 dq_reg   [0:FW];
    logic [SW-1:0]                 drem_next [1:FW];
    logic [FW-1:0]                 dq_next   [1:FW];

    logic [DW-1:0]                 mag;
    logic [QW-1:0]                 res_mag;
    logic signed [QW-1:0]          res;
    logic                          ov_reg;
    logic signed [FIELD_W-1:0]     cos_reg;

    always_comb
    begin
        ll_next = r2[RH-1:0] * v2[VH-1:0];
        lh_next = r2[RH-1:0] * v2[V2W-1:VH];
        hl_next = r2[R2W-1:RH] * v2[VH-1:0];
        hh_next = r2[R2W-1:RH] * v2[V2W-1:VH];
        prod = XW'(ll_reg) + (XW'(lh_reg) << VH) + (XW'(hl_reg) << RH)
             + (XW'(hh_reg) << (RH + VH));
    end

    always_comb
    begin
        logic [SW+2:0] tmp;
        logic [SW+2:0] trial;
        for (int k = 0; k < SW; k++)
        begin
            tmp   = {srem_reg[k], sx_reg[k][XW-1 -: 2]};
            trial = {1'b0, sroot_reg[k], 2'b01};
            sx_next[k+1] = sx_reg[k] << 2;
            if (tmp >= trial)
            begin
                srem_next[k+1]  = (SW+1)'(tmp - trial);
                sroot_next[k+1] = {sroot_reg[k][SW-2:0], 1'b1};
            end
            else
            begin
                srem_next[k+1]  = tmp[SW:0];
                sroot_next[k+1] = {sroot_reg[k][SW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        logic [SW:0] rem2;
        mag = ss_reg[SW].dot[DW-1] ? DW'(-ss_reg[SW].dot) : DW'(ss_reg[SW].dot);
        for (int k = 0; k < FW; k++)
        begin
            rem2 = {drem_reg[k], 1'b0};
            if (rem2 >= {1'b0, ds_reg[k]})
            begin
                drem_next[k+1] = SW'(rem2 - {1'b0, ds_reg[k]});
                dq_next[k+1]   = {dq_reg[k][FW-2:0], 1'b1};
            end
            else
            begin
                drem_next[k+1] = rem2[SW-1:0];
                dq_next[k+1]   = {dq_reg[k][FW-2:0], 1'b0};
            end
        end
    end

    // Zero vectors override the quotient; an overshoot of the floor root saturates.
    always_comb
    begin
        if (df_reg[FW].rz && df_reg[FW].vz)
        begin
            res_mag = ONE;
        end
        else if (df_reg[FW].rz || df_reg[FW].vz)
        begin
            res_mag = '0;
        end
        else if (df_reg[FW].sat)
        begin
            res_mag = ONE;
        end
        else
        begin
            res_mag = {2'b00, dq_reg[FW]};
        end
        res = df_reg[FW].neg ? $signed(-res_mag) : $signed(res_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            ov_reg <= 1'b0;
            for (int k = 0; k <= SW; k++)
            begin
                sv_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= FW; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            pv_reg    <= src_valid;
            sv_reg[0] <= pv_reg;
            for (int k = 0; k < SW; k++)
            begin
                sv_reg[k+1] <= sv_reg[k];
            end
            dv_reg[0] <= sv_reg[SW];
            for (int k = 0; k < FW; k++)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
            ov_reg <= dv_reg[FW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ps_reg    <= '{rz: (r2 == '0), vz: (v2 == '0), dot: dot};
            ll_reg    <= ll_next;
            lh_reg    <= lh_next;
            hl_reg    <= hl_next;
            hh_reg    <= hh_next;

            ss_reg[0]    <= ps_reg;
            sx_reg[0]    <= prod;
            srem_reg[0]  <= '0;
            sroot_reg[0] <= '0;
            for (int k = 1; k <= SW; k++)
            begin
                ss_reg[k]    <= ss_reg[k-1];
                sx_reg[k]    <= sx_next[k];
                srem_reg[k]  <= srem_next[k];
                sroot_reg[k] <= sroot_next[k];
            end

            df_reg[0]   <= '{rz: ss_reg[SW].rz, vz: ss_reg[SW].vz,
                             neg: ss_reg[SW].dot[DW-1],
                             sat: (mag >= DW'(sroot_reg[SW]))};
            ds_reg[0]   <= sroot_reg[SW];
            drem_reg[0] <= SW'(mag);
            dq_reg[0]   <= '0;
            for (int k = 1; k <= FW; k++)
            begin
                df_reg[k]   <= df_reg[k-1];
                ds_reg[k]   <= ds_reg[k-1];
                drem_reg[k] <= drem_next[k];
                dq_reg[k]   <= dq_next[k];
            end

            cos_reg <= FIELD_W'(res);
        end
    end

    assign dst_valid = ov_reg;
    assign cos_val   = cos_reg;

    // A zero vector gives a zero product and so a zero root.
    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        (sv_reg[SW] && (ss_reg[SW].rz || ss_reg[SW].vz)) |-> (sroot_reg[SW] == '0))
        else $error("nonzero root for a zero vector");

    // Without saturation the final remainder stays below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg[FW] && !df_reg[FW].sat && !df_reg[FW].rz && !df_reg[FW].vz)
        |-> (drem_reg[FW] < ds_reg[FW]))
        else $error("division remainder not below divisor");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg[FW] |-> (res_mag <= ONE))
        else $error("cosine magnitude above one");

endmodule

`default_nettype wire

### sv/sum_vector_angle_cosines_unit.sv
// Sum-vector angle cosines. Each transfer on the item channel carries three
// 3D vectors A, B and C; the unit forms R = A + B + C and returns, in one
// result transfer, the cosine of the angle between R and each of A, B and C
// as trunc(dot * 2^COS_FRAC_BITS / isqrt(|R|^2 * |V|^2)), rounded toward zero
// and saturated to plus or minus 2^COS_FRAC_BITS (Q1.14 by default). A pair
// of zero vectors reads as cosine one, a single zero vector as zero. Only the
// low COMP_WIDTH bits of each component are used, as a signed value. The unit
// is a fully pipelined datapath that takes one item every clock cycle while
// no result is stalled; its depth is set by the square root, which resolves
// one root bit per stage, and the divider, which resolves one quotient bit
// per stage. A stalled result freezes the whole pipeline, and the item channel
// stalls for exactly those cycles.
`default_nettype none

module sum_vector_angle_cosines_unit #(
    parameter int COMP_WIDTH    = svac_pkg::COMP_WIDTH_DEF,
    parameter int COS_FRAC_BITS = svac_pkg::COS_FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  svac_pkg::svac_item_t   item,
    input  logic                   item_valid,
    output logic                   item_stall,
    output svac_pkg::svac_result_t result,
    output logic                   result_valid,
    input  logic                   result_stall
);
    import svac_pkg::*;

    localparam int CW  = COMP_WIDTH;
    localparam int RW  = CW + 2;
    localparam int R2W = 2 * RW;
    localparam int V2W = 2 * CW;
    localparam int DW  = 2 * CW + 3;

    logic signed [FIELD_W-1:0] field [0:8];

    // Stage 1: components and the sum vector.
    logic                  s1v_reg;
    logic signed [CW-1:0]  v_reg [0:2][0:2];
    logic signed [RW-1:0]  r_reg [0:2];
    logic signed [CW-1:0]  comp  [0:2][0:2];

    // Stage 2: all element products.
    logic                    s2v_reg;
    logic signed [2*RW-1:0]  rr_reg [0:2];
    logic signed [2*CW-1:0]  vv_reg [0:2][0:2];
    logic signed [RW+CW-1:0] rv_reg [0:2][0:2];

    // Stage 3: squared lengths and dot products.
    logic                  s3v_reg;
    logic [R2W-1:0]        r2_reg;
    logic [V2W-1:0]        v2_reg  [0:2];
    logic signed [DW-1:0]  dot_reg [0:2];

    logic                        en;
    logic                        lane_valid [0:2];
    logic signed [FIELD_W-1:0]   lane_cos   [0:2];

    // The pipeline moves unless a finished result is held back.
    assign en         = !(result_valid && result_stall);
    assign item_stall = !en;

    assign field[0] = item.a_x;
    assign field[1] = item.a_y;
    assign field[2] = item.a_z;
    assign field[3] = item.b_x;
    assign field[4] = item.b_y;
    assign field[5] = item.b_z;
    assign field[6] = item.c_x;
    assign field[7] = item.c_y;
    assign field[8] = item.c_z;

    // Bits above COMP_WIDTH are dropped; a wider COMP_WIDTH zero-extends.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                comp[k][j] = $signed(CW'($unsigned(field[k*3+j])));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1v_reg <= 1'b0;
            s2v_reg <= 1'b0;
            s3v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1v_reg <= item_valid;
            s2v_reg <= s1v_reg;
            s3v_reg <= s2v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r_reg[j] <= RW'(comp[0][j]) + RW'(comp[1][j]) + RW'(comp[2][j]);
                rr_reg[j] <= r_reg[j] * r_reg[j];
                for (int k = 0; k < 3; k++)
                begin
                    v_reg[k][j]  <= comp[k][j];
                    vv_reg[k][j] <= v_reg[k][j] * v_reg[k][j];
                    rv_reg[k][j] <= r_reg[j] * v_reg[k][j];
                end
            end
            r2_reg <= R2W'($unsigned(rr_reg[0])) + R2W'($unsigned(rr_reg[1]))
                    + R2W'($unsigned(rr_reg[2]));
            for (int k = 0; k < 3; k++)
            begin
                v2_reg[k] <= V2W'($unsigned(vv_reg[k][0])) + V2W'($unsigned(vv_reg[k][1]))
                           + V2W'($unsigned(vv_reg[k][2]));
                dot_reg[k] <= DW'(rv_reg[k][0]) + DW'(rv_reg[k][1]) + DW'(rv_reg[k][2]);
            end
        end
    end

    // One cosine lane per input vector; all three run in lockstep.
    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        svac_lane #(
            .COMP_WIDTH    (COMP_WIDTH),
            .COS_FRAC_BITS (COS_FRAC_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .src_valid (s3v_reg),
            .r2        (r2_reg),
            .v2        (v2_reg[g]),
            .dot       (dot_reg[g]),
            .dst_valid (lane_valid[g]),
            .cos_val   (lane_cos[g])
        );
    end

    assign result_valid  = lane_valid[0];
    assign result.cos_ra = lane_cos[0];
    assign result.cos_rb = lane_cos[1];
    assign result.cos_rc = lane_cos[2];

    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_valid[0] == lane_valid[1]) && (lane_valid[1] == lane_valid[2]))
        else $error("cosine lanes out of step");

    // The squared length of R is zero exactly when every square is zero.
    a_r2_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s2v_reg && en) |=> ((r2_reg == '0) ==
            $past((rr_reg[0] == '0) && (rr_reg[1] == '0) && (rr_reg[2] == '0))))
        else $error("squared length of sum vector wrong");

    // A zero vector has a zero dot product with anything.
    a_zero_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (s3v_reg && (v2_reg[0] == '0)) |-> (dot_reg[0] == '0))
        else $error("nonzero dot product for zero vector");

endmodule

`default_nettype wire

### tb/sv/tb_sum_vector_angle_cosines_unit.sv
`timescale 1ns / 1ps

// Testbench for the sum-vector angle cosine unit. A table of directed vector
// triples runs first, then random triples. Every accepted item is passed
// through a local integer model of the cosine math, and the expected result
// is queued. Each result transfer is checked against the oldest queued entry.
module tb_sum_vector_angle_cosines_unit;
    import svac_pkg::*;

    localparam int COMP_W    = COMP_WIDTH_DEF;
    localparam int FRAC_BITS = COS_FRAC_BITS_DEF;
    localparam int LATENCY   = 2 * COMP_W + FRAC_BITS + 9;
    localparam int N_RANDOM  = 1300;
    localparam int N_DIRECTED = 14;

    logic         clk;
    logic         rst_n;
    svac_item_t   item;
    logic         item_valid;
    logic         item_stall;
    svac_result_t result;
    logic         result_valid;
    logic         result_stall;

    sum_vector_angle_cosines_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // Expected results, oldest first.
    svac_result_t cos_queue[$];
    int           n_errors;
    bit           stim_done;
    bit           long_hold;

    // Directed rows; has_exp marks rows whose cosines are known by inspection.
    svac_item_t   dir_item[N_DIRECTED];
    svac_result_t dir_exp[N_DIRECTED];
    bit           dir_has_exp[N_DIRECTED];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Watchdog: far above the slowest legal run (each item waiting out its longest
    // gap plus its longest stall, plus pipeline latency).
    initial
    begin
        #(8 * 400000);
        $display("RESULT: ERROR");
        $finish;
    end

    // Floor square root of a 128-bit value, one root bit per step.
    function automatic logic [63:0] floor_sqrt128(logic [127:0] val);
        logic [63:0]  root;
        logic [63:0]  trial;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if ({64'd0, trial} * {64'd0, trial} <= val)
                root = trial;
        end
        return root;
    endfunction

    // Cosine of one vector against the sum, saturated, in Q1.14.
    function automatic logic [15:0] cos_fixed(longint dot, logic [63:0] r2,
                                              logic [63:0] v2);
        logic [63:0] one;
        logic [63:0] root;
        logic [63:0] mag;
        logic [63:0] quo;
        logic [63:0] rem;
        one = 64'd1 << FRAC_BITS;
        if (r2 == 0 || v2 == 0)
            return (r2 == 0 && v2 == 0) ? one[15:0] : 16'd0;
        root = floor_sqrt128({64'd0, r2} * {64'd0, v2});
        mag  = (dot < 0) ? -dot : dot;
        if (mag >= root)
            quo = one;
        else
        begin
            rem = mag;
            quo = '0;
            for (int i = 0; i < FRAC_BITS; i++)
            begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= root)
                begin
                    rem = rem - root;
                    quo[0] = 1'b1;
                end
            end
        end
        if (dot < 0)
            quo = -quo;
        return quo[15:0];
    endfunction

    function automatic longint sext_comp(logic [15:0] raw);
        logic signed [COMP_W-1:0] low;
        low = raw[COMP_W-1:0];
        return longint'(low);
    endfunction

    function automatic svac_result_t predict_cosines(svac_item_t it);
        longint       vec[3][3];
        longint       sum[3];
        longint       dot;
        logic [63:0]  r2;
        logic [63:0]  v2;
        logic [15:0]  cosv[3];
        svac_result_t res;
        vec[0][0] = sext_comp(it.a_x);
        vec[0][1] = sext_comp(it.a_y);
        vec[0][2] = sext_comp(it.a_z);
        vec[1][0] = sext_comp(it.b_x);
        vec[1][1] = sext_comp(it.b_y);
        vec[1][2] = sext_comp(it.b_z);
        vec[2][0] = sext_comp(it.c_x);
        vec[2][1] = sext_comp(it.c_y);
        vec[2][2] = sext_comp(it.c_z);
        for (int j = 0; j < 3; j++)
            sum[j] = vec[0][j] + vec[1][j] + vec[2][j];
        r2 = sum[0] * sum[0] + sum[1] * sum[1] + sum[2] * sum[2];
        for (int k = 0; k < 3; k++)
        begin
            v2 = vec[k][0] * vec[k][0] + vec[k][1] * vec[k][1]
                 + vec[k][2] * vec[k][2];
            dot = sum[0] * vec[k][0] + sum[1] * vec[k][1] + sum[2] * vec[k][2];
            cosv[k] = cos_fixed(dot, r2, v2);
        end
        res.cos_ra = cosv[0];
        res.cos_rb = cosv[1];
        res.cos_rc = cosv[2];
        return res;
    endfunction

    function automatic svac_item_t make_item(int ax, int ay, int az, int bx,
                                             int by, int bz, int cx, int cy,
                                             int cz);
        svac_item_t it;
        it = {16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz),
              16'(cx), 16'(cy), 16'(cz)};
        return it;
    endfunction

    // Random component: mostly full range, some small or extreme values so
    // that zero vectors and near-parallel sums come up often.
    function automatic logic [15:0] rand_comp();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return 16'($urandom);
        else if (sel < 7)
            return 16'($urandom_range(0, 6) - 3);
        else if (sel == 7)
            return 16'h8000;
        else if (sel == 8)
            return 16'h7fff;
        return 16'h0000;
    endfunction

    function automatic svac_item_t rand_item();
        svac_item_t it;
        int shape;
        for (int f = 0; f < 9; f++)
            it[f*16 +: 16] = rand_comp();
        shape = $urandom_range(0, 7);
        // Some triples where C is the negated 16-bit sum of A and B, so the sum is zero
        // unless that wraps, and some where the three vectors are all equal and every cosine is one.
        if (shape == 0)
        begin
            it.c_x = -(it.a_x + it.b_x);
            it.c_y = -(it.a_y + it.b_y);
            it.c_z = -(it.a_z + it.b_z);
        end
        else if (shape == 1)
        begin
            it.b_x = it.a_x; it.b_y = it.a_y; it.b_z = it.a_z;
            it.c_x = it.a_x; it.c_y = it.a_y; it.c_z = it.a_z;
        end
        else if (shape == 2)
        begin
            it.a_x = 16'($urandom_range(0, 6) - 3);
            it.a_y = 16'($urandom_range(0, 6) - 3);
            it.a_z = 16'($urandom_range(0, 6) - 3);
        end
        return it;
    endfunction

    // Valid drops only for a real gap, so back-to-back items keep it high.
    task automatic send_one(svac_item_t it);
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        // Wait for the edge at which the transfer completes.
        do
            @(posedge clk);
        while (item_stall);
        cos_queue.push_back(predict_cosines(it));
        @(negedge clk);
    endtask

    // Directed rows. Expected values are filled in where they are obvious.
    initial
    begin
        for (int i = 0; i < N_DIRECTED; i++)
            dir_has_exp[i] = 1'b0;
        // All zero: both sum and each vector are zero, cosine one.
        dir_item[0] = make_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
        dir_exp[0] = {16'sd16384, 16'sd16384, 16'sd16384};
        dir_has_exp[0] = 1'b1;
        // Sum zero while A and B are not: cosine zero for those, one for C.
        dir_item[1] = make_item(5, 0, 0, -5, 0, 0, 0, 0, 0);
        dir_exp[1] = {16'sd0, 16'sd0, 16'sd16384};
        dir_has_exp[1] = 1'b1;
        // Only A non-zero: parallel to the sum; B and C zero, sum not zero.
        dir_item[2] = make_item(3, 4, 0, 0, 0, 0, 0, 0, 0);
        dir_exp[2] = {16'sd16384, 16'sd0, 16'sd0};
        dir_has_exp[2] = 1'b1;
        // Three equal vectors at the extremes.
        dir_item[3] = make_item(32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767);
        dir_exp[3] = {16'sd16384, 16'sd16384, 16'sd16384};
        dir_has_exp[3] = 1'b1;
        dir_item[4] = make_item(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768);
        dir_exp[4] = {16'sd16384, 16'sd16384, 16'sd16384};
        dir_has_exp[4] = 1'b1;
        // A opposite to a larger B: negative cosine saturated at minus one.
        dir_item[5] = make_item(-1, 0, 0, 3, 0, 0, 0, 0, 0);
        dir_exp[5] = {-16'sd16384, 16'sd16384, 16'sd0};
        dir_has_exp[5] = 1'b1;
        // Orthogonal unit vectors: the floor root makes the divider saturate at one.
        dir_item[6] = make_item(1, 0, 0, 0, 1, 0, 0, 0, 1);
        dir_item[7] = make_item(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767);
        dir_item[8] = make_item(-32768, 32767, -32768, 32767, -32768, 32767,
                                1, -1, 1);
        dir_item[9] = make_item(1, 2, 3, -4, 5, -6, 7, -8, 9);
        dir_item[10] = make_item(32767, 0, 0, 0, 32767, 0, -32768, -32768, 0);
        dir_item[11] = make_item(100, -200, 300, -100, 201, -299, 1, 1, 1);
        dir_item[12] = make_item(-1, -1, -1, 0, 0, 0, 1, 1, 1);
        dir_item[13] = make_item(12345, -23456, 7, -30000, 31000, -5, 2, 3, 4);
    end

    // Sender: directed table, then random items.
    initial
    begin
        item       = '0;
        item_valid = 1'b0;
        rst_n      = 1'b0;
        n_errors   = 0;
        stim_done  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (dir_has_exp[i] && predict_cosines(dir_item[i]) != dir_exp[i])
            begin
                $error("directed row %0d: table %h, model %h", i, dir_exp[i],
                       predict_cosines(dir_item[i]));
                n_errors++;
            end
            send_one(dir_item[i]);
        end
        for (int i = 0; i < N_RANDOM; i++)
            send_one(rand_item());
        item_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stall per result, with one long hold-off early on
    // while the sender keeps offering items, so the pipeline backs up.
    initial
    begin
        int wait_cycles;
        int n_seen;
        n_seen = 0;
        result_stall = 1'b1;
        long_hold = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!long_hold && n_seen == 40)
            begin
                long_hold = 1'b1;
                result_stall <= 1'b1;
                repeat (150) @(negedge clk);
            end
            wait_cycles = $urandom_range(0, 18);
            if ($urandom_range(0, 3) == 0)
                wait_cycles = 0;
            if (wait_cycles != 0)
            begin
                result_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
            n_seen++;
            @(negedge clk);
        end
    end

    // Checker: compares each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        svac_result_t exp_res;
        if (rst_n && result_valid && !result_stall)
        begin
            if (cos_queue.size() == 0)
            begin
                $error("result with nothing expected: %h", result);
                n_errors++;
            end
            else
            begin
                exp_res = cos_queue.pop_front();
                if (result.cos_ra !== exp_res.cos_ra)
                begin
                    $error("cos_ra expected %0d actual %0d", exp_res.cos_ra,
                           result.cos_ra);
                    n_errors++;
                end
                if (result.cos_rb !== exp_res.cos_rb)
                begin
                    $error("cos_rb expected %0d actual %0d", exp_res.cos_rb,
                           result.cos_rb);
                    n_errors++;
                end
                if (result.cos_rc !== exp_res.cos_rc)
                begin
                    $error("cos_rc expected %0d actual %0d", exp_res.cos_rc,
                           result.cos_rc);
                    n_errors++;
                end
            end
        end
    end

    // End of run: drain the queue, allow a further latency for strays.
    initial
    begin
        wait (stim_done);
        wait (cos_queue.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (n_errors == 0 && cos_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
